/* sv/rss_pkg.sv */
package rss_pkg;

    localparam int InDataW  = 168;
    localparam int OutDataW = 136;
    localparam int TimeW    = 63;
    localparam int BudgetW  = 32;
    localparam int CfgDataW = 63;
    localparam int CfgIdxW  = 2;

    localparam logic [TimeW-1:0]   WorldTimeoutRst   = 63'd1000000000;
    localparam logic [TimeW-1:0]   RouteTimeoutRst   = 63'd1000000000;
    localparam logic [TimeW-1:0]   HorizonTimeoutRst = 63'd1000000000;
    localparam logic [BudgetW-1:0] RecoveryBudgetRst = 32'd3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_WORLD_TIMEOUT   = 2'd0,
        CFG_ROUTE_TIMEOUT   = 2'd1,
        CFG_HORIZON_TIMEOUT = 2'd2,
        CFG_RECOVERY_BUDGET = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        STAGE_PROCESS_ALIVE = 3'd0,
        STAGE_WORLD_READY   = 3'd1,
        STAGE_BOOTSTRAP     = 3'd2,
        STAGE_CERT_ROUTE    = 3'd3,
        STAGE_FIRST_HORIZON = 3'd4,
        STAGE_MISSION_READY = 3'd5,
        STAGE_TERMINAL      = 3'd6
    } stage_t;

    typedef enum logic [2:0] {
        FAIL_NONE      = 3'd0,
        FAIL_NO_WORLD  = 3'd1,
        FAIL_NO_ROUTE  = 3'd2,
        FAIL_NO_HORIZ  = 3'd3,
        FAIL_NO_BUDGET = 3'd4
    } failure_t;

    typedef struct packed {
        logic [TimeW-1:0]   world_timeout_ns;
        logic [TimeW-1:0]   route_timeout_ns;
        logic [TimeW-1:0]   horizon_timeout_ns;
        logic [BudgetW-1:0] recovery_budget;
    } cfg_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic               horizon_acked;
        logic               route_certified;
        logic               boot_done;
        logic               map_avail;
        logic               nav_alive;
        logic signed [63:0] timestamp_ns;
        logic [63:0]        recovery_seq;
        logic [31:0]        op_epoch;
        logic               op_active;
    } in_item_t;

    typedef struct packed {
        logic             pad;
        logic             is_terminal;
        logic             ready_res;
        logic [TimeW-1:0] stage_age_ns;
        logic [31:0]      attempts;
        logic [31:0]      epoch_out;
        failure_t         failure;
        stage_t           stage;
    } out_item_t;

endpackage

/* sv/rss_cfg.sv */
module rss_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rss_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [rss_pkg::CfgDataW-1:0]    cfg_wdata,
    output rss_pkg::cfg_t                   cfg
);
    import rss_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.world_timeout_ns   <= WorldTimeoutRst;
            cfg_reg.route_timeout_ns   <= RouteTimeoutRst;
            cfg_reg.horizon_timeout_ns <= HorizonTimeoutRst;
            cfg_reg.recovery_budget    <= RecoveryBudgetRst;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_WORLD_TIMEOUT:   cfg_reg.world_timeout_ns   <= cfg_wdata[TimeW-1:0];
                CFG_ROUTE_TIMEOUT:   cfg_reg.route_timeout_ns   <= cfg_wdata[TimeW-1:0];
                CFG_HORIZON_TIMEOUT: cfg_reg.horizon_timeout_ns <= cfg_wdata[TimeW-1:0];
                CFG_RECOVERY_BUDGET: cfg_reg.recovery_budget    <= cfg_wdata[BudgetW-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

/* sv/rss_core.sv */
module rss_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  rss_pkg::cfg_t       cfg,
    input  rss_pkg::in_item_t   item,
    input  logic                advance,
    output rss_pkg::out_item_t  result
);
    import rss_pkg::*;

    stage_t           stage_reg, stage_next;
    failure_t         fail_reg, fail_next;
    logic [31:0]      epoch_reg, epoch_next;
    logic [63:0]      seq_reg, seq_next;
    logic [TimeW-1:0] entry_reg, entry_next;
    logic [31:0]      att_reg, att_next;
    logic             term_reg, term_next;

    logic             clr, new_ep, seq_up, changed;
    logic [TimeW-1:0] now;
    stage_t           b_stage, want;
    failure_t         b_fail, fail;
    logic [63:0]      b_seq, delta;
    logic [TimeW-1:0] b_entry, age_b, age;
    logic [31:0]      b_att, n_att, sat_att;
    logic             b_term;
    logic [32:0]      sum33;
    logic [63:0]      diff;

    always_comb begin
        clr    = !item.op_active || (item.op_epoch == 32'd0) ||
                 item.timestamp_ns[63] || (item.timestamp_ns == 64'sd0);
        new_ep = item.op_epoch != epoch_reg;
        now    = item.timestamp_ns[TimeW-1:0];

        // a new epoch starts from cleared state with baseline and stamp
        b_stage = new_ep ? STAGE_PROCESS_ALIVE : stage_reg;
        b_fail  = new_ep ? FAIL_NONE : fail_reg;
        b_seq   = new_ep ? item.recovery_seq : seq_reg;
        b_entry = new_ep ? now : entry_reg;
        b_att   = new_ep ? 32'd0 : att_reg;
        b_term  = new_ep ? 1'b0 : term_reg;

        // saturating attempt count
        seq_up = item.recovery_seq > b_seq;
        delta  = item.recovery_seq - b_seq;
        sum33  = {1'b0, b_att} + {1'b0, delta[31:0]};
        if ((delta[63:32] != 32'd0) || sum33[32]) begin
            sat_att = '1;
        end else begin
            sat_att = sum33[31:0];
        end
        n_att = seq_up ? sat_att : b_att;

        want = STAGE_PROCESS_ALIVE;
        if (item.nav_alive) begin
            want = STAGE_WORLD_READY;
            if (item.map_avail) begin
                want = STAGE_BOOTSTRAP;
                if (item.boot_done) begin
                    want = STAGE_CERT_ROUTE;
                    if (item.route_certified) begin
                        want = STAGE_FIRST_HORIZON;
                        if (item.horizon_acked) begin
                            want = STAGE_MISSION_READY;
                        end
                    end
                end
            end
        end
        changed = want != b_stage;

        // entry of zero means unstamped
        diff  = {1'b0, now} - {1'b0, b_entry};
        age_b = ((b_entry == '0) || diff[63]) ? '0 : diff[TimeW-1:0];
        age   = changed ? '0 : age_b;

        if (item.boot_done && !item.map_avail &&
                age >= cfg.world_timeout_ns) begin
            fail = FAIL_NO_WORLD;
        end else if (item.boot_done && item.map_avail && !item.route_certified &&
                age >= cfg.route_timeout_ns) begin
            fail = FAIL_NO_ROUTE;
        end else if (item.route_certified && !item.horizon_acked &&
                age >= cfg.horizon_timeout_ns) begin
            fail = FAIL_NO_HORIZ;
        end else if (!item.route_certified && n_att >= cfg.recovery_budget) begin
            fail = FAIL_NO_BUDGET;
        end else begin
            fail = FAIL_NONE;
        end

        result     = '0;
        stage_next = stage_reg;
        fail_next  = fail_reg;
        epoch_next = epoch_reg;
        seq_next   = seq_reg;
        entry_next = entry_reg;
        att_next   = att_reg;
        term_next  = term_reg;

        if (clr) begin
            stage_next = STAGE_PROCESS_ALIVE;
            fail_next  = FAIL_NONE;
            epoch_next = '0;
            seq_next   = '0;
            entry_next = '0;
            att_next   = '0;
            term_next  = 1'b0;
        end else if (b_term) begin
            // latched: state held, report terminal
            result.stage        = STAGE_TERMINAL;
            result.failure      = b_fail;
            result.epoch_out    = item.op_epoch;
            result.attempts     = b_att;
            result.stage_age_ns = age_b;
            result.is_terminal  = 1'b1;
        end else begin
            epoch_next = item.op_epoch;
            seq_next   = seq_up ? item.recovery_seq : b_seq;
            att_next   = n_att;
            fail_next  = fail;
            if (fail != FAIL_NONE) begin
                stage_next = STAGE_TERMINAL;
                entry_next = now;
                term_next  = 1'b1;
            end else begin
                stage_next = want;
                entry_next = changed ? now : b_entry;
                term_next  = 1'b0;
            end
            result.stage        = stage_next;
            result.failure      = fail;
            result.epoch_out    = item.op_epoch;
            result.attempts     = n_att;
            result.stage_age_ns = (fail != FAIL_NONE) ? '0 : age;
            result.ready_res    = (fail == FAIL_NONE) && (want == STAGE_MISSION_READY);
            result.is_terminal  = fail != FAIL_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= STAGE_PROCESS_ALIVE;
            fail_reg  <= FAIL_NONE;
            epoch_reg <= '0;
            seq_reg   <= '0;
            entry_reg <= '0;
            att_reg   <= '0;
            term_reg  <= 1'b0;
        end else if (advance) begin
            stage_reg <= stage_next;
            fail_reg  <= fail_next;
            epoch_reg <= epoch_next;
            seq_reg   <= seq_next;
            entry_reg <= entry_next;
            att_reg   <= att_next;
            term_reg  <= term_next;
        end
    end
endmodule

/* sv/readiness_stage_supervisor.sv */
// readiness stage supervisor
// s_ channel: one observation per beat; tdata from bit 0 up holds op_active,
// op_epoch, recovery_seq, timestamp_ns, the five readiness flags, then zeros.
// m_ channel: one result per observation; tdata from bit 0 up holds stage,
// failure, epoch_out, attempts, stage_age_ns, ready_res, is_terminal, one zero.
// cfg_ port: register i of the list is written at cfg_index i while cfg_we is
// high; write only while no observation is in flight.
// path: a taken beat is held in the input register, evaluated against the tracked
// state and registered in the result register once that register is free.
// throughput: one beat per cycle while m_tready stays high; the state update is
// combinational compare, subtract and saturating add between input and result registers.
// stall: the result register holds while m_tready is low; the input register
// still takes one beat then, and s_tready drops only when both are full.
// reset: aresetn low clears tracking state, empties both registers and loads
// the register defaults (timeouts 1e9 ns, recovery budget 3).
module readiness_stage_supervisor (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // active, epoch, recovery_seq, timestamp_ns, alive, world, boot, route, horizon
    input  logic [rss_pkg::InDataW-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stage, failure, epoch_out, attempts, stage_age_ns, ready_res, is_terminal
    output logic [rss_pkg::OutDataW-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [rss_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [rss_pkg::CfgDataW-1:0]    cfg_wdata
);
    import rss_pkg::*;

    cfg_t      cfg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      out_free, advance;

    rss_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (in_reg),
        .advance (advance),
        .result  (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= in_item_t'(s_tdata);
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule
